[design/grb_pkg.sv]
// Shared types, constants and helper functions of the GPIO register block.
// No dependencies; every other file of the block refers to this package.
package grb_pkg;

    localparam int NUM_PINS      = 54;
    localparam int BANK_BITS     = 32;
    localparam int HIGH_BITS     = 22;
    localparam int EXT_BITS      = 64;
    localparam int FSEL_WORDS    = 6;
    localparam int PINS_PER_WORD = 10;
    localparam int CODE_BITS     = 3;
    localparam int FSEL_BITS     = PINS_PER_WORD * CODE_BITS;
    localparam int FSEL_PINS     = FSEL_WORDS * PINS_PER_WORD;
    localparam int FSEL_IDX_BITS = $clog2(FSEL_WORDS);

    localparam logic [CODE_BITS-1:0] CODE_OUTPUT = 3'd1;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [3:0] IDX_FSEL0 = 4'd0;
    localparam logic [3:0] IDX_FSEL1 = 4'd1;
    localparam logic [3:0] IDX_FSEL2 = 4'd2;
    localparam logic [3:0] IDX_FSEL3 = 4'd3;
    localparam logic [3:0] IDX_FSEL4 = 4'd4;
    localparam logic [3:0] IDX_FSEL5 = 4'd5;
    localparam logic [3:0] IDX_SET0  = 4'd6;
    localparam logic [3:0] IDX_SET1  = 4'd7;
    localparam logic [3:0] IDX_CLR0  = 4'd8;
    localparam logic [3:0] IDX_CLR1  = 4'd9;
    localparam logic [3:0] IDX_LEV0  = 4'd10;
    localparam logic [3:0] IDX_LEV1  = 4'd11;
    localparam logic [3:0] IDX_PULL  = 4'd12;
    localparam logic [3:0] IDX_PCLK0 = 4'd13;
    localparam logic [3:0] IDX_PCLK1 = 4'd14;
    localparam logic [3:0] IDX_BAD   = 4'd15;

    localparam logic [1:0] PULL_OFF  = 2'd0;
    localparam logic [1:0] PULL_DOWN = 2'd1;
    localparam logic [1:0] PULL_UP   = 2'd2;

    typedef logic [NUM_PINS-1:0] t_pins;

    typedef struct packed {
        logic                 req_type;
        logic [3:0]           reg_index;
        logic [31:0]          write_data;
        logic [31:0]          pad_in_low;
        logic [HIGH_BITS-1:0] pad_in_high;
    } t_req;

    typedef struct packed {
        logic [31:0]          read_data;
        logic                 bad_index;
        logic [31:0]          drive_low;
        logic [HIGH_BITS-1:0] drive_high;
        logic [31:0]          enable_low;
        logic [HIGH_BITS-1:0] enable_high;
        logic [31:0]          pullup_low;
        logic [HIGH_BITS-1:0] pullup_high;
        logic [31:0]          pulldown_low;
        logic [HIGH_BITS-1:0] pulldown_high;
    } t_rsp;

    // Places a 32-bit bank mask at pins 0-31 or at pins 32 and up.
    function automatic t_pins bank_bits(input logic bank, input logic [31:0] data);
        logic [EXT_BITS-1:0] v;
        v = bank ? {data, 32'd0} : {32'd0, data};
        return v[NUM_PINS-1:0];
    endfunction

    // Code bits of a function-select word that belong to existing pins.
    function automatic logic [FSEL_BITS-1:0] word_mask(input logic [FSEL_IDX_BITS-1:0] w);
        logic [FSEL_BITS-1:0] m;
        m = '0;
        for (int k = 0; k < PINS_PER_WORD; k++) begin
            if (int'(w) * PINS_PER_WORD + k < NUM_PINS) begin
                m[k*CODE_BITS +: CODE_BITS] = '1;
            end
        end
        return m;
    endfunction

    // Upper pin half of a pin vector, cut to the width of the high fields.
    function automatic logic [HIGH_BITS-1:0] high_part(input t_pins p);
        logic [EXT_BITS-1:0] v;
        v = EXT_BITS'(p);
        return v[BANK_BITS +: HIGH_BITS];
    endfunction

endpackage

[design/grb_if.sv]
// Valid/ready channel interfaces for requests and results of the GPIO block.
// Depends on grb_pkg for field widths.
interface gpio_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [3:0]                    reg_index;
    logic [31:0]                   write_data;
    logic [31:0]                   pad_in_low;
    logic [grb_pkg::HIGH_BITS-1:0] pad_in_high;

    modport source (output valid, input ready,
                    output req_type, reg_index, write_data, pad_in_low, pad_in_high);
    modport sink   (input valid, output ready,
                    input req_type, reg_index, write_data, pad_in_low, pad_in_high);
endinterface

interface gpio_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [31:0]                   read_data;
    logic                          bad_index;
    logic [31:0]                   drive_low;
    logic [grb_pkg::HIGH_BITS-1:0] drive_high;
    logic [31:0]                   enable_low;
    logic [grb_pkg::HIGH_BITS-1:0] enable_high;
    logic [31:0]                   pullup_low;
    logic [grb_pkg::HIGH_BITS-1:0] pullup_high;
    logic [31:0]                   pulldown_low;
    logic [grb_pkg::HIGH_BITS-1:0] pulldown_high;

    modport source (output valid, input ready,
                    output read_data, bad_index, drive_low, drive_high,
                    output enable_low, enable_high, pullup_low, pullup_high,
                    output pulldown_low, pulldown_high);
    modport sink   (input valid, output ready,
                    input read_data, bad_index, drive_low, drive_high,
                    input enable_low, enable_high, pullup_low, pullup_high,
                    input pulldown_low, pulldown_high);
endinterface

[design/grb_req_stage.sv]
// Input register of the GPIO block: captures one bus request per cycle while the core does not stall it.
// Depends on grb_pkg and gpio_req_if.
module grb_req_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gpio_req_if.sink        i_req,
    input  logic            i_advance,
    output logic            o_valid,
    output grb_pkg::t_req   o_req
);

    logic          r_valid;
    grb_pkg::t_req r_req;
    logic          take;

    assign i_req.ready = !r_valid || i_advance;
    assign take        = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req.req_type    <= i_req.req_type;
            r_req.reg_index   <= i_req.reg_index;
            r_req.write_data  <= i_req.write_data;
            r_req.pad_in_low  <= i_req.pad_in_low;
            r_req.pad_in_high <= i_req.pad_in_high;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

[design/grb_core.sv]
// Register file of the GPIO block: applies one request to the pin state and
// registers the result. Depends on grb_pkg and gpio_rsp_if.
module grb_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  grb_pkg::t_req   i_req,
    output logic            o_advance,
    gpio_rsp_if.source      o_rsp
);

    logic [grb_pkg::FSEL_BITS-1:0] r_fsel [grb_pkg::FSEL_WORDS];
    logic [grb_pkg::FSEL_BITS-1:0] n_fsel [grb_pkg::FSEL_WORDS];
    grb_pkg::t_pins                r_latch, n_latch;
    grb_pkg::t_pins                r_pup, n_pup;
    grb_pkg::t_pins                r_pdn, n_pdn;
    logic [1:0]                    r_pull, n_pull;
    logic                          r_out_valid;
    grb_pkg::t_rsp                 r_rsp, n_rsp;

    logic                               wr;
    logic [grb_pkg::FSEL_IDX_BITS-1:0]  widx;
    logic [grb_pkg::EXT_BITS-1:0]       pads;
    grb_pkg::t_pins                     pads_pins;
    grb_pkg::t_pins                     n_en;
    grb_pkg::t_pins                     clk_bits;
    logic [31:0]                        rd;
    logic                               bad;

    assign o_advance = i_valid && (!r_out_valid || o_rsp.ready);
    assign wr        = (i_req.req_type == grb_pkg::REQ_WRITE);
    assign widx      = i_req.reg_index[grb_pkg::FSEL_IDX_BITS-1:0];
    assign pads_pins = grb_pkg::t_pins'({{(grb_pkg::EXT_BITS - grb_pkg::BANK_BITS
                                            - grb_pkg::HIGH_BITS){1'b0}},
                                          i_req.pad_in_high, i_req.pad_in_low});
    assign pads      = grb_pkg::EXT_BITS'(pads_pins);
    assign clk_bits  = grb_pkg::bank_bits(i_req.reg_index == grb_pkg::IDX_PCLK1,
                                          i_req.write_data);

    always_comb begin
        for (int w = 0; w < grb_pkg::FSEL_WORDS; w++) begin
            n_fsel[w] = r_fsel[w];
        end
        n_latch = r_latch;
        n_pup   = r_pup;
        n_pdn   = r_pdn;
        n_pull  = r_pull;
        rd      = '0;
        bad     = 1'b0;
        case (i_req.reg_index)
            grb_pkg::IDX_FSEL0, grb_pkg::IDX_FSEL1, grb_pkg::IDX_FSEL2,
            grb_pkg::IDX_FSEL3, grb_pkg::IDX_FSEL4, grb_pkg::IDX_FSEL5: begin
                if (wr) begin
                    n_fsel[widx] = i_req.write_data[grb_pkg::FSEL_BITS-1:0]
                                   & grb_pkg::word_mask(widx);
                end else begin
                    rd = 32'(r_fsel[widx]);
                end
            end
            grb_pkg::IDX_SET0, grb_pkg::IDX_SET1: begin
                if (wr) begin
                    n_latch = r_latch | grb_pkg::bank_bits(
                        i_req.reg_index == grb_pkg::IDX_SET1, i_req.write_data);
                end
            end
            grb_pkg::IDX_CLR0, grb_pkg::IDX_CLR1: begin
                if (wr) begin
                    n_latch = r_latch & ~grb_pkg::bank_bits(
                        i_req.reg_index == grb_pkg::IDX_CLR1, i_req.write_data);
                end
            end
            grb_pkg::IDX_LEV0: begin
                rd = pads[31:0];
            end
            grb_pkg::IDX_LEV1: begin
                rd = pads[grb_pkg::BANK_BITS +: 32];
            end
            grb_pkg::IDX_PULL: begin
                if (wr) begin
                    n_pull = i_req.write_data[1:0];
                end else begin
                    rd = 32'(r_pull);
                end
            end
            grb_pkg::IDX_PCLK0, grb_pkg::IDX_PCLK1: begin
                if (wr) begin
                    case (r_pull)
                        grb_pkg::PULL_OFF: begin
                            n_pup = r_pup & ~clk_bits;
                            n_pdn = r_pdn & ~clk_bits;
                        end
                        grb_pkg::PULL_DOWN: begin
                            n_pup = r_pup & ~clk_bits;
                            n_pdn = r_pdn | clk_bits;
                        end
                        grb_pkg::PULL_UP: begin
                            n_pup = r_pup | clk_bits;
                            n_pdn = r_pdn & ~clk_bits;
                        end
                        default: begin
                            n_pup = r_pup;
                            n_pdn = r_pdn;
                        end
                    endcase
                end
            end
            grb_pkg::IDX_BAD: begin
                bad = 1'b1;
            end
            default: begin
                bad = 1'b0;
            end
        endcase
        if (wr) begin
            rd = '0;
        end
    end

    always_comb begin
        n_en = '0;
        for (int p = 0; p < grb_pkg::NUM_PINS; p++) begin
            if (p < grb_pkg::FSEL_PINS) begin
                n_en[p] = (n_fsel[p / grb_pkg::PINS_PER_WORD]
                           [(p % grb_pkg::PINS_PER_WORD) * grb_pkg::CODE_BITS
                            +: grb_pkg::CODE_BITS] == grb_pkg::CODE_OUTPUT);
            end
        end
    end

    always_comb begin
        n_rsp.read_data     = rd;
        n_rsp.bad_index     = bad;
        n_rsp.drive_low     = n_latch[31:0];
        n_rsp.drive_high    = grb_pkg::high_part(n_latch);
        n_rsp.enable_low    = n_en[31:0];
        n_rsp.enable_high   = grb_pkg::high_part(n_en);
        n_rsp.pullup_low    = n_pup[31:0];
        n_rsp.pullup_high   = grb_pkg::high_part(n_pup);
        n_rsp.pulldown_low  = n_pdn[31:0];
        n_rsp.pulldown_high = grb_pkg::high_part(n_pdn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < grb_pkg::FSEL_WORDS; w++) begin
                r_fsel[w] <= '0;
            end
            r_latch     <= '0;
            r_pup       <= '0;
            r_pdn       <= '0;
            r_pull      <= grb_pkg::PULL_OFF;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                for (int w = 0; w < grb_pkg::FSEL_WORDS; w++) begin
                    r_fsel[w] <= n_fsel[w];
                end
                r_latch     <= n_latch;
                r_pup       <= n_pup;
                r_pdn       <= n_pdn;
                r_pull      <= n_pull;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_rsp.read_data;
    assign o_rsp.bad_index     = r_rsp.bad_index;
    assign o_rsp.drive_low     = r_rsp.drive_low;
    assign o_rsp.drive_high    = r_rsp.drive_high;
    assign o_rsp.enable_low    = r_rsp.enable_low;
    assign o_rsp.enable_high   = r_rsp.enable_high;
    assign o_rsp.pullup_low    = r_rsp.pullup_low;
    assign o_rsp.pullup_high   = r_rsp.pullup_high;
    assign o_rsp.pulldown_low  = r_rsp.pulldown_low;
    assign o_rsp.pulldown_high = r_rsp.pulldown_high;

endmodule

[design/gpio_register_block.sv]
// Top level of the GPIO register block: input register followed by the core.
// Depends on grb_pkg, gpio_req_if, gpio_rsp_if, grb_req_stage and grb_core.
//
// The block takes one register request per cycle on i_req, while the result
// side is not stalled, and returns one result for each request on o_rsp,
// after it has passed the input register and then the result register.
// A request is applied to the function-select words, output latch and pull
// state in the cycle it leaves the input register, and the result shows the
// pin state after that access. The input register frees whenever the result
// register is empty or being taken, so i_req.ready follows o_rsp.ready
// combinationally and a new request is accepted while a finished result
// still waits. The state resets to all pins input, latch clear, pulls off.
module gpio_register_block (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gpio_req_if.sink     i_req,
    gpio_rsp_if.source   o_rsp
);

    logic          stage_valid;
    logic          advance;
    grb_pkg::t_req stage_req;

    grb_req_stage u_req_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_req     (stage_req)
    );

    grb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (stage_valid),
        .i_req     (stage_req),
        .o_advance (advance),
        .o_rsp     (o_rsp)
    );

endmodule

[design/grb_checker.sv]
// Port-level checks of the GPIO register block, bound to the top level.
// Depends on grb_pkg for field widths and on gpio_register_block.
module grb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [31:0]                   i_read_data,
    input logic                          i_bad_index,
    input logic [31:0]                   i_pullup_low,
    input logic [grb_pkg::HIGH_BITS-1:0] i_pullup_high,
    input logic [31:0]                   i_pulldown_low,
    input logic [grb_pkg::HIGH_BITS-1:0] i_pulldown_high
);

    a_no_result_after_reset: assert property (
        @(posedge i_clk) $past(!i_rst_n) |-> !i_rsp_valid)
        else $error("Result valid in the cycle after reset.");

    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_read_data)
                                        && $stable(i_bad_index))
        else $error("Stalled result changed or dropped.");

    a_bad_reads_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_bad_index |-> i_read_data == 32'd0)
        else $error("Unmapped request returned nonzero data.");

    a_pull_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ((i_pullup_low & i_pulldown_low) == 32'd0)
                        && ((i_pullup_high & i_pulldown_high) == '0))
        else $error("Pin shows pull-up and pull-down at once.");

endmodule

bind gpio_register_block grb_checker u_grb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_read_data     (o_rsp.read_data),
    .i_bad_index     (o_rsp.bad_index),
    .i_pullup_low    (o_rsp.pullup_low),
    .i_pullup_high   (o_rsp.pullup_high),
    .i_pulldown_low  (o_rsp.pulldown_low),
    .i_pulldown_high (o_rsp.pulldown_high)
);

[tb/sv/gpio_register_block_test.sv]
// Self-checking testbench for gpio_register_block: register requests against a pin-state predictor.
// Depends on grb_pkg, gpio_req_if, gpio_rsp_if and the gpio_register_block RTL.
`timescale 1ns / 100ps

module gpio_register_block_test;

    localparam int CLK_HALF        = 10;
    localparam int RANDOM_REQUESTS = 1625;
    localparam int PRESSURE_AT     = 700;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [1:0] PULL_RESERVED = 2'd3;

    typedef enum int {TAKE_ALL, TAKE_COIN, TAKE_PERIODIC, TAKE_SPARSE} t_sink_mode;

    typedef struct {
        grb_pkg::t_req req;
        bit            typed;
        grb_pkg::t_rsp want;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    gpio_req_if req_ch ();
    gpio_rsp_if rsp_ch ();

    gpio_register_block i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic [grb_pkg::FSEL_BITS-1:0] fsel_shadow [grb_pkg::FSEL_WORDS];
    grb_pkg::t_pins                latch_shadow;
    grb_pkg::t_pins                pullup_shadow;
    grb_pkg::t_pins                pulldown_shadow;
    logic [1:0]                    pull_code_shadow;

    grb_pkg::t_rsp pin_state_due [$];
    t_dir_row      directed_rows [$];
    int            mismatches    = 0;
    int            requests_taken = 0;
    int            burst_left    = 0;
    int            idle_cycles   = 0;

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic grb_pkg::t_pins bank_pins(input logic upper, input logic [31:0] d);
        return upper ? {d[grb_pkg::HIGH_BITS-1:0], {grb_pkg::BANK_BITS{1'b0}}}
                     : grb_pkg::t_pins'(d);
    endfunction

    function automatic logic [grb_pkg::FSEL_BITS-1:0] fsel_valid_bits(input int w);
        int pins_here;
        pins_here = grb_pkg::NUM_PINS - w * grb_pkg::PINS_PER_WORD;
        if (pins_here <= 0) begin
            return '0;
        end
        if (pins_here > grb_pkg::PINS_PER_WORD) begin
            pins_here = grb_pkg::PINS_PER_WORD;
        end
        return grb_pkg::FSEL_BITS'((64'd1 << (pins_here * grb_pkg::CODE_BITS)) - 64'd1);
    endfunction

    function automatic void clear_pin_shadow();
        foreach (fsel_shadow[w]) begin
            fsel_shadow[w] = '0;
        end
        latch_shadow     = '0;
        pullup_shadow    = '0;
        pulldown_shadow  = '0;
        pull_code_shadow = grb_pkg::PULL_OFF;
    endfunction

    // Applies one request to the shadow state and returns the pin report that follows it.
    function automatic grb_pkg::t_rsp gpio_access_effect(input grb_pkg::t_req r);
        grb_pkg::t_rsp  res;
        grb_pkg::t_pins en;
        grb_pkg::t_pins clocked;
        int             w;
        logic           wr;
        res = '0;
        wr  = (r.req_type == grb_pkg::REQ_WRITE);
        case (r.reg_index)
            grb_pkg::IDX_FSEL0, grb_pkg::IDX_FSEL1, grb_pkg::IDX_FSEL2,
            grb_pkg::IDX_FSEL3, grb_pkg::IDX_FSEL4, grb_pkg::IDX_FSEL5: begin
                w = int'(r.reg_index - grb_pkg::IDX_FSEL0);
                if (wr) begin
                    fsel_shadow[w] = r.write_data[grb_pkg::FSEL_BITS-1:0]
                                     & fsel_valid_bits(w);
                end else begin
                    res.read_data = 32'(fsel_shadow[w]);
                end
            end
            grb_pkg::IDX_SET0, grb_pkg::IDX_SET1: begin
                if (wr) begin
                    latch_shadow |= bank_pins(r.reg_index == grb_pkg::IDX_SET1,
                                              r.write_data);
                end
            end
            grb_pkg::IDX_CLR0, grb_pkg::IDX_CLR1: begin
                if (wr) begin
                    latch_shadow &= ~bank_pins(r.reg_index == grb_pkg::IDX_CLR1,
                                               r.write_data);
                end
            end
            grb_pkg::IDX_LEV0: begin
                if (!wr) begin
                    res.read_data = r.pad_in_low;
                end
            end
            grb_pkg::IDX_LEV1: begin
                if (!wr) begin
                    res.read_data = 32'(r.pad_in_high);
                end
            end
            grb_pkg::IDX_PULL: begin
                if (wr) begin
                    pull_code_shadow = r.write_data[1:0];
                end else begin
                    res.read_data = 32'(pull_code_shadow);
                end
            end
            grb_pkg::IDX_PCLK0, grb_pkg::IDX_PCLK1: begin
                if (wr) begin
                    clocked = bank_pins(r.reg_index == grb_pkg::IDX_PCLK1, r.write_data);
                    case (pull_code_shadow)
                        grb_pkg::PULL_OFF: begin
                            pullup_shadow   &= ~clocked;
                            pulldown_shadow &= ~clocked;
                        end
                        grb_pkg::PULL_DOWN: begin
                            pullup_shadow   &= ~clocked;
                            pulldown_shadow |= clocked;
                        end
                        grb_pkg::PULL_UP: begin
                            pullup_shadow   |= clocked;
                            pulldown_shadow &= ~clocked;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            grb_pkg::IDX_BAD: begin
                res.bad_index = 1'b1;
            end
            default: begin
            end
        endcase
        for (int p = 0; p < grb_pkg::NUM_PINS; p++) begin
            en[p] = fsel_shadow[p / grb_pkg::PINS_PER_WORD]
                    [(p % grb_pkg::PINS_PER_WORD) * grb_pkg::CODE_BITS +: grb_pkg::CODE_BITS]
                    == grb_pkg::CODE_OUTPUT;
        end
        res.drive_low     = latch_shadow[grb_pkg::BANK_BITS-1:0];
        res.drive_high    = latch_shadow[grb_pkg::NUM_PINS-1:grb_pkg::BANK_BITS];
        res.enable_low    = en[grb_pkg::BANK_BITS-1:0];
        res.enable_high   = en[grb_pkg::NUM_PINS-1:grb_pkg::BANK_BITS];
        res.pullup_low    = pullup_shadow[grb_pkg::BANK_BITS-1:0];
        res.pullup_high   = pullup_shadow[grb_pkg::NUM_PINS-1:grb_pkg::BANK_BITS];
        res.pulldown_low  = pulldown_shadow[grb_pkg::BANK_BITS-1:0];
        res.pulldown_high = pulldown_shadow[grb_pkg::NUM_PINS-1:grb_pkg::BANK_BITS];
        return res;
    endfunction

    function automatic grb_pkg::t_rsp idle_rsp(input logic [31:0] rd, input logic bad);
        grb_pkg::t_rsp res;
        res           = '0;
        res.read_data = rd;
        res.bad_index = bad;
        return res;
    endfunction

    // A function-select word in which about half of the pins are made outputs.
    function automatic logic [31:0] output_heavy_word();
        logic [31:0] w;
        w = $urandom;
        for (int k = 0; k < grb_pkg::PINS_PER_WORD; k++) begin
            if ($urandom_range(0, 1) == 1) begin
                w[k * grb_pkg::CODE_BITS +: grb_pkg::CODE_BITS] = grb_pkg::CODE_OUTPUT;
            end
        end
        return w;
    endfunction

    function automatic grb_pkg::t_req random_request();
        grb_pkg::t_req r;
        int            pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            r.reg_index = grb_pkg::IDX_FSEL0
                          + 4'($urandom_range(0, grb_pkg::FSEL_WORDS - 1));
        end else if (pick < 45) begin
            r.reg_index = grb_pkg::IDX_SET0 + 4'($urandom_range(0, 3));
        end else if (pick < 55) begin
            r.reg_index = grb_pkg::IDX_LEV0 + 4'($urandom_range(0, 1));
        end else if (pick < 65) begin
            r.reg_index = grb_pkg::IDX_PULL;
        end else if (pick < 85) begin
            r.reg_index = grb_pkg::IDX_PCLK0 + 4'($urandom_range(0, 1));
        end else if (pick < 90) begin
            r.reg_index = grb_pkg::IDX_BAD;
        end else begin
            r.reg_index = 4'($urandom);
        end
        r.req_type = ($urandom_range(0, 9) < 6) ? grb_pkg::REQ_WRITE : grb_pkg::REQ_READ;
        case ($urandom_range(0, 9))
            0:       r.write_data = '1;
            1:       r.write_data = '0;
            2:       r.write_data = 32'd1 << $urandom_range(0, 31);
            3, 4:    r.write_data = output_heavy_word();
            default: r.write_data = $urandom;
        endcase
        r.pad_in_low  = $urandom;
        r.pad_in_high = grb_pkg::HIGH_BITS'($urandom);
        return r;
    endfunction

    function automatic void add_row(input logic kind, input logic [3:0] idx,
                                    input logic [31:0] data, input bit pads_high,
                                    input bit typed, input grb_pkg::t_rsp want);
        t_dir_row row;
        row.req.req_type    = kind;
        row.req.reg_index   = idx;
        row.req.write_data  = data;
        row.req.pad_in_low  = pads_high ? '1 : 32'($urandom);
        row.req.pad_in_high = pads_high ? '1 : grb_pkg::HIGH_BITS'($urandom);
        row.typed           = typed;
        row.want            = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_table();
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_FSEL0, '0, 0, 1, idle_rsp('0, 1'b0));
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_LEV0,  '0, 1, 1, idle_rsp('1, 1'b0));
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_LEV1,  '0, 1, 1, idle_rsp(32'h003F_FFFF, 1'b0));
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_BAD,   '1, 0, 1, idle_rsp('0, 1'b1));
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_BAD,   '1, 0, 1, idle_rsp('0, 1'b1));
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_LEV1,  '1, 1, 1, idle_rsp('0, 1'b0));
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PCLK0, '1, 0, 1, idle_rsp('0, 1'b0));
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_SET0,  '1, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_SET1,  '1, 0, 0, '0);
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_SET1,  '0, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_CLR0,  32'h5555_5555, 0, 0, '0);
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_CLR0,  '0, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_CLR1,  '1, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_FSEL0, '1, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_FSEL5, '1, 0, 0, '0);
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_FSEL5, '0, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_FSEL2, 32'h0924_9249, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_FSEL5, 32'h0924_9249, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PULL,  32'(grb_pkg::PULL_UP), 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PCLK0, '1, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PCLK1, '1, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PULL,  32'(grb_pkg::PULL_DOWN), 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PCLK1, 32'h0030_0003, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PULL,  32'(PULL_RESERVED), 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PCLK0, '1, 0, 0, '0);
        add_row(grb_pkg::REQ_READ,  grb_pkg::IDX_PULL,  '0, 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PULL,  32'(grb_pkg::PULL_OFF), 0, 0, '0);
        add_row(grb_pkg::REQ_WRITE, grb_pkg::IDX_PCLK0, 32'hF0F0_F0F0, 0, 0, '0);
    endfunction

    // Offers one request, with a random gap before each burst, and logs its expected report.
    task automatic offer_request(input grb_pkg::t_req r, input bit typed,
                                 input grb_pkg::t_rsp want);
        int            gap;
        grb_pkg::t_rsp predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= r.req_type;
        req_ch.reg_index   <= r.reg_index;
        req_ch.write_data  <= r.write_data;
        req_ch.pad_in_low  <= r.pad_in_low;
        req_ch.pad_in_high <= r.pad_in_high;
        do @(posedge clk); while (!req_ch.ready);
        predicted = gpio_access_effect(r);
        pin_state_due.push_back(typed ? want : predicted);
        requests_taken++;
        burst_left--;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    task automatic compare_rsp(input grb_pkg::t_rsp want);
        check_field("read_data",     want.read_data,          rsp_ch.read_data);
        check_field("bad_index",     32'(want.bad_index),     32'(rsp_ch.bad_index));
        check_field("drive_low",     want.drive_low,          rsp_ch.drive_low);
        check_field("drive_high",    32'(want.drive_high),    32'(rsp_ch.drive_high));
        check_field("enable_low",    want.enable_low,         rsp_ch.enable_low);
        check_field("enable_high",   32'(want.enable_high),   32'(rsp_ch.enable_high));
        check_field("pullup_low",    want.pullup_low,         rsp_ch.pullup_low);
        check_field("pullup_high",   32'(want.pullup_high),   32'(rsp_ch.pullup_high));
        check_field("pulldown_low",  want.pulldown_low,       rsp_ch.pulldown_low);
        check_field("pulldown_high", 32'(want.pulldown_high), 32'(rsp_ch.pulldown_high));
    endtask

    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pin_state_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result with no request outstanding: read_data %h",
                             rsp_ch.read_data);
                end
            end else begin
                compare_rsp(pin_state_due.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("gpio_register_block: mismatch");
                $finish;
            end
        end
    end

    // Result side: stall patterns that change every stretch, plus one long hold-off.
    initial begin : result_sink
        t_sink_mode mode;
        int         stretch;
        int         phase;
        int         hold_left;
        bit         pressure_done;
        logic       take;
        phase         = 0;
        hold_left     = 0;
        pressure_done = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            mode    = t_sink_mode'($urandom_range(0, 3));
            stretch = $urandom_range(10, 80);
            repeat (stretch) begin
                @(posedge clk);
                phase++;
                if (!pressure_done && requests_taken >= PRESSURE_AT) begin
                    pressure_done = 1;
                    hold_left     = HOLD_OFF_CYCLES;
                end
                case (mode)
                    TAKE_ALL:      take = 1'b1;
                    TAKE_COIN:     take = 1'($urandom_range(0, 1));
                    TAKE_PERIODIC: take = (phase % 4) != 0;
                    default:       take = ($urandom_range(0, 3) == 0);
                endcase
                if (hold_left > 0) begin
                    take = 1'b0;
                    hold_left--;
                end
                rsp_ch.ready <= take;
            end
        end
    end

    initial begin : request_source
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= grb_pkg::REQ_READ;
        req_ch.reg_index   <= grb_pkg::IDX_FSEL0;
        req_ch.write_data  <= '0;
        req_ch.pad_in_low  <= '0;
        req_ch.pad_in_high <= '0;
        clear_pin_shadow();
        build_directed_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (directed_rows[i]) begin
            offer_request(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].want);
        end
        repeat (RANDOM_REQUESTS) begin
            offer_request(random_request(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;
        while (pin_state_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("gpio_register_block: match");
        end else begin
            $display("gpio_register_block: mismatch");
        end
        $finish;
    end

endmodule
